/* sv/dpfa_pkg.sv */
`timescale 1ns / 1ps

package dpfa_pkg;

    // default sizing of the allocator
    localparam int PROCESSES_DEF = 8;
    localparam int PAGES_DEF     = 2048;
    localparam int FRAMES_DEF    = 12288;

    // running fault counter, wraps
    localparam int FAULT_W = 32;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACC,
        ST_REL,
        ST_HOLD
    } state_t;

    // index width for a store of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* sv/dpfa_ram.sv */
`timescale 1ns / 1ps

module dpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [dpfa_pkg::idx_w(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [dpfa_pkg::idx_w(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/demand_page_frame_allocator.sv */
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_action, s_process, s_page
// m_        out        m_valid / m_ready  m_hit, m_fault, m_out_of_frames, m_frame,
//                                         m_freed_count, m_process_frames, m_free_left,
//                                         m_fault_total
//
// access: page table, free stack and held-count reads as the request is accepted, then
//   modify and write back in ST_ACC (the memories have registered reads)
// release: one page table entry read per cycle in the walk
// reset: a clearing pass over max(PROCESSES * PAGES_PER_PROCESS, FRAMES) addresses (16384 by
//   default) fills the free stack and clears the tables; s_ready stays low meanwhile
// a stalled m_ stage parks the next finished result in a holding register; s_ready
//   returns once that result has moved into the output register
`timescale 1ns / 1ps

module demand_page_frame_allocator #(
    parameter int PROCESSES         = dpfa_pkg::PROCESSES_DEF,
    parameter int PAGES_PER_PROCESS = dpfa_pkg::PAGES_DEF,
    parameter int FRAMES            = dpfa_pkg::FRAMES_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,

    input  logic                                                s_valid,
    output logic                                                s_ready,
    input  logic                                                s_action,
    input  logic [dpfa_pkg::idx_w(PROCESSES)-1:0]               s_process,
    input  logic [dpfa_pkg::idx_w(PAGES_PER_PROCESS)-1:0]       s_page,

    output logic                                                m_valid,
    input  logic                                                m_ready,
    output logic                                                m_hit,
    output logic                                                m_fault,
    output logic                                                m_out_of_frames,
    output logic [dpfa_pkg::idx_w(FRAMES)-1:0]                  m_frame,
    output logic [dpfa_pkg::idx_w(PAGES_PER_PROCESS+1)-1:0]     m_freed_count,
    output logic [dpfa_pkg::idx_w(PAGES_PER_PROCESS+1)-1:0]     m_process_frames,
    output logic [dpfa_pkg::idx_w(FRAMES+1)-1:0]                m_free_left,
    output logic [dpfa_pkg::FAULT_W-1:0]                        m_fault_total
);

    // sizing
    localparam int ENTRIES  = PROCESSES * PAGES_PER_PROCESS;
    localparam int PROC_W   = dpfa_pkg::idx_w(PROCESSES);
    localparam int PAGE_W   = dpfa_pkg::idx_w(PAGES_PER_PROCESS);
    localparam int PT_AW    = dpfa_pkg::idx_w(ENTRIES);
    localparam int FRAME_W  = dpfa_pkg::idx_w(FRAMES);
    localparam int CNT_W    = dpfa_pkg::idx_w(FRAMES + 1);
    localparam int HELD_W   = dpfa_pkg::idx_w(PAGES_PER_PROCESS + 1);
    localparam int ENTRY_W  = FRAME_W + 1;
    localparam int FAULT_W  = dpfa_pkg::FAULT_W;
    localparam int INIT_LEN = (ENTRIES > FRAMES) ? ENTRIES : FRAMES;
    localparam int INIT_W   = dpfa_pkg::idx_w(INIT_LEN + 1);

    // one result transaction
    typedef struct packed {
        logic                hit;
        logic                fault;
        logic                oof;
        logic [FRAME_W-1:0]  frame;
        logic [HELD_W-1:0]   freed;
        logic [HELD_W-1:0]   held;
        logic [CNT_W-1:0]    free_left;
        logic [FAULT_W-1:0]  fault_total;
    } res_t;

    // control state
    dpfa_pkg::state_t    state_reg, state_next;
    logic [INIT_W-1:0]   init_cnt_reg;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [FAULT_W-1:0]  fault_cnt_reg, fault_cnt_next;
    logic                m_valid_reg, m_valid_next;

    // per-transaction context
    logic [PROC_W-1:0]   proc_reg;
    logic                oor_reg;
    logic [PT_AW-1:0]    base_reg;
    logic [HELD_W-1:0]   walk_reg;
    logic [PT_AW-1:0]    prev_addr_reg;
    logic [HELD_W-1:0]   freed_reg, freed_next;
    res_t                out_reg;
    res_t                hold_reg;

    // memory ports
    logic                pt_we;
    logic [PT_AW-1:0]    pt_waddr, pt_raddr;
    logic [ENTRY_W-1:0]  pt_wdata, pt_rdata;
    logic                st_we;
    logic [FRAME_W-1:0]  st_waddr, st_raddr, st_wdata, st_rdata;
    logic                held_we;
    logic [PROC_W-1:0]   held_waddr, held_raddr;
    logic [HELD_W-1:0]   held_wdata, held_rdata;

    // helpers
    logic                accept;
    logic                out_free;
    logic                finish;
    logic                proc_oor, page_oor, oor_in;
    logic [PT_AW-1:0]    base_in;
    logic [CNT_W-1:0]    free_dec;
    logic                walk_last;
    res_t                res;

    assign s_ready  = (state_reg == dpfa_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // range checks and table base for the incoming transaction
    assign proc_oor = {1'b0, s_process} >= (PROC_W + 1)'(PROCESSES);
    assign page_oor = {1'b0, s_page} >= (PAGE_W + 1)'(PAGES_PER_PROCESS);
    assign oor_in   = proc_oor || (!s_action && page_oor);
    assign base_in  = PT_AW'(s_process) * PT_AW'(PAGES_PER_PROCESS);

    assign free_dec  = free_count_reg - CNT_W'(1);
    assign walk_last = (walk_reg == HELD_W'(PAGES_PER_PROCESS));

    // page table: {valid, frame} per entry
    dpfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_page_table (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // free frame stack, top at free_count - 1
    dpfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_free_stack (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // frames held per process
    dpfa_ram #(
        .WIDTH (HELD_W),
        .DEPTH (PROCESSES)
    ) u_held (
        .aclk  (aclk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (held_raddr),
        .rdata (held_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpfa_pkg::ST_INIT: begin
                if (init_cnt_reg == INIT_W'(INIT_LEN - 1)) begin
                    state_next = dpfa_pkg::ST_IDLE;
                end
            end
            dpfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_action && !oor_in) ? dpfa_pkg::ST_REL : dpfa_pkg::ST_ACC;
                end
            end
            dpfa_pkg::ST_ACC: begin
                state_next = out_free ? dpfa_pkg::ST_IDLE : dpfa_pkg::ST_HOLD;
            end
            dpfa_pkg::ST_REL: begin
                if (walk_last) begin
                    state_next = out_free ? dpfa_pkg::ST_IDLE : dpfa_pkg::ST_HOLD;
                end
            end
            dpfa_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = dpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dpfa_pkg::ST_INIT;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        pt_we           = 1'b0;
        pt_waddr        = prev_addr_reg;
        pt_wdata        = '0;
        pt_raddr        = base_in + PT_AW'(s_page);
        st_we           = 1'b0;
        st_waddr        = free_count_reg[FRAME_W-1:0];
        st_wdata        = '0;
        st_raddr        = free_dec[FRAME_W-1:0];
        held_we         = 1'b0;
        held_waddr      = proc_reg;
        held_wdata      = '0;
        held_raddr      = s_process;
        free_count_next = free_count_reg;
        fault_cnt_next  = fault_cnt_reg;
        freed_next      = accept ? '0 : freed_reg;
        finish          = 1'b0;
        res             = '0;

        case (state_reg)
            dpfa_pkg::ST_INIT: begin
                // clearing pass: invalid entries, identity stack, zero counts
                pt_we      = init_cnt_reg < INIT_W'(ENTRIES);
                pt_waddr   = init_cnt_reg[PT_AW-1:0];
                st_we      = init_cnt_reg < INIT_W'(FRAMES);
                st_waddr   = init_cnt_reg[FRAME_W-1:0];
                st_wdata   = init_cnt_reg[FRAME_W-1:0];
                held_we    = init_cnt_reg < INIT_W'(PROCESSES);
                held_waddr = init_cnt_reg[PROC_W-1:0];
            end
            dpfa_pkg::ST_ACC: begin
                finish = 1'b1;
                if (!oor_reg) begin
                    if (pt_rdata[FRAME_W]) begin
                        res.hit   = 1'b1;
                        res.frame = pt_rdata[FRAME_W-1:0];
                        res.held  = held_rdata;
                    end else begin
                        res.fault      = 1'b1;
                        fault_cnt_next = fault_cnt_reg + FAULT_W'(1);
                        if (free_count_reg == '0) begin
                            res.oof  = 1'b1;
                            res.held = held_rdata;
                        end else begin
                            // pop the stack top and map it
                            free_count_next = free_dec;
                            pt_we           = 1'b1;
                            pt_wdata        = {1'b1, st_rdata};
                            held_we         = 1'b1;
                            held_wdata      = held_rdata + HELD_W'(1);
                            res.frame       = st_rdata;
                            res.held        = held_wdata;
                        end
                    end
                end
                res.free_left   = free_count_next;
                res.fault_total = fault_cnt_next;
            end
            dpfa_pkg::ST_REL: begin
                pt_raddr = base_reg + PT_AW'(walk_reg);
                // entry read last cycle: clear it, push its frame if mapped and the stack is not full
                if (walk_reg != '0) begin
                    pt_we = 1'b1;
                    if (pt_rdata[FRAME_W] && (free_count_reg < CNT_W'(FRAMES))) begin
                        st_we           = 1'b1;
                        st_wdata        = pt_rdata[FRAME_W-1:0];
                        free_count_next = free_count_reg + CNT_W'(1);
                        freed_next      = freed_reg + HELD_W'(1);
                    end
                end
                if (walk_last) begin
                    finish          = 1'b1;
                    held_we         = 1'b1;
                    res.freed       = freed_next;
                    res.free_left   = free_count_next;
                    res.fault_total = fault_cnt_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dpfa_pkg::ST_INIT;
            init_cnt_reg   <= '0;
            free_count_reg <= CNT_W'(FRAMES);
            fault_cnt_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            fault_cnt_reg  <= fault_cnt_next;
            m_valid_reg    <= m_valid_next;
            if (state_reg == dpfa_pkg::ST_INIT) begin
                init_cnt_reg <= init_cnt_reg + INIT_W'(1);
            end
        end
    end

    // output register: a new result, a parked result, or drained by the sink
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((finish || (state_reg == dpfa_pkg::ST_HOLD)) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // payload and context registers
    always_ff @(posedge aclk) begin
        prev_addr_reg <= pt_raddr;
        freed_reg     <= freed_next;
        if (accept) begin
            proc_reg <= s_process;
            oor_reg  <= oor_in;
            base_reg <= base_in;
            walk_reg <= '0;
        end else if (state_reg == dpfa_pkg::ST_REL) begin
            walk_reg <= walk_reg + HELD_W'(1);
        end
        if (finish && out_free) begin
            out_reg <= res;
        end else if ((state_reg == dpfa_pkg::ST_HOLD) && out_free) begin
            out_reg <= hold_reg;
        end
        if (finish && !out_free) begin
            hold_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = out_reg.hit;
    assign m_fault          = out_reg.fault;
    assign m_out_of_frames  = out_reg.oof;
    assign m_frame          = out_reg.frame;
    assign m_freed_count    = out_reg.freed;
    assign m_process_frames = out_reg.held;
    assign m_free_left      = out_reg.free_left;
    assign m_fault_total    = out_reg.fault_total;

    // the free stack never holds more than every frame
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= CNT_W'(FRAMES))
        else $error("free frame count above frame total");

    // a served fault pops exactly one frame
    a_pop_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpfa_pkg::ST_ACC && !oor_reg && !pt_rdata[FRAME_W]
         && free_count_reg != '0)
        |=> free_count_reg == $past(free_dec))
        else $error("fault did not pop one frame");

    // a hit leaves the stack and the fault counter alone
    a_hit_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpfa_pkg::ST_ACC && !oor_reg && pt_rdata[FRAME_W])
        |=> $stable(free_count_reg) && $stable(fault_cnt_reg))
        else $error("hit changed allocator counters");

    // the release walk stops after the last page
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dpfa_pkg::ST_REL) |-> walk_reg <= HELD_W'(PAGES_PER_PROCESS))
        else $error("release walk ran past the page table");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    // sizes of the block as built
    localparam int NPROC   = dpfa_pkg::PROCESSES_DEF;
    localparam int NPAGES  = dpfa_pkg::PAGES_DEF;
    localparam int NFRAMES = dpfa_pkg::FRAMES_DEF;
    localparam int PROC_W  = dpfa_pkg::idx_w(NPROC);
    localparam int PAGE_W  = dpfa_pkg::idx_w(NPAGES);
    localparam int FRAME_W = dpfa_pkg::idx_w(NFRAMES);
    localparam int CNT_W   = dpfa_pkg::idx_w(NPAGES + 1);
    localparam int LEFT_W  = dpfa_pkg::idx_w(NFRAMES + 1);
    localparam int FAULT_W = dpfa_pkg::FAULT_W;

    // request kinds carried on s_action
    typedef enum logic {
        ACT_ACCESS  = 1'b0,
        ACT_RELEASE = 1'b1
    } page_action_t;

    typedef struct packed {
        logic              action;
        logic [PROC_W-1:0] process;
        logic [PAGE_W-1:0] page;
    } page_request_t;

    typedef struct packed {
        logic               hit;
        logic               fault;
        logic               out_of_frames;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   freed_count;
        logic [CNT_W-1:0]   process_frames;
        logic [LEFT_W-1:0]  free_left;
        logic [FAULT_W-1:0] fault_total;
    } page_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid  = 1'b0;
    logic              s_ready;
    logic              s_action = 1'b0;
    logic [PROC_W-1:0] s_process = '0;
    logic [PAGE_W-1:0] s_page    = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic               m_fault;
    logic               m_out_of_frames;
    logic [FRAME_W-1:0] m_frame;
    logic [CNT_W-1:0]   m_freed_count;
    logic [CNT_W-1:0]   m_process_frames;
    logic [LEFT_W-1:0]  m_free_left;
    logic [FAULT_W-1:0] m_fault_total;

    // mirror of the allocator state
    logic [FRAME_W-1:0] map_frame   [0:NPROC*NPAGES-1];
    bit                 map_valid   [0:NPROC*NPAGES-1];
    logic [FRAME_W-1:0] spare_frames[0:NFRAMES-1];
    int unsigned        free_top;
    int unsigned        held        [0:NPROC-1];
    logic [FAULT_W-1:0] fault_count;

    page_request_t request_queue[$];
    page_result_t  expected_results[$];

    int unsigned mismatches    = 0;
    int unsigned results_taken = 0;
    bit          fed           = 1'b0;   // an input transaction went through at the last rising edge

    // sender burst state
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // receiver stall state
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 30;
    int unsigned mode_left    = 0;
    int unsigned ready_mode   = 0;

    demand_page_frame_allocator uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_process        (s_process),
        .s_page           (s_page),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_fault          (m_fault),
        .m_out_of_frames  (m_out_of_frames),
        .m_frame          (m_frame),
        .m_freed_count    (m_freed_count),
        .m_process_frames (m_process_frames),
        .m_free_left      (m_free_left),
        .m_fault_total    (m_fault_total)
    );

    always #6 aclk = ~aclk;

    // applies one request to the mirrored tables and returns what the block must answer
    function automatic page_result_t step_allocator(input page_request_t req);
        page_result_t res;
        int unsigned  slot;
        int unsigned  returned;
        res  = '0;
        slot = req.process * NPAGES;
        if (req.action == ACT_RELEASE) begin
            // walk every page of the process, low page first, pushing frames back
            returned = 0;
            for (int p = 0; p < NPAGES; p++) begin
                if (map_valid[slot + p]) begin
                    // a push onto a full stack is dropped but the entry is still cleared
                    if (free_top < NFRAMES) begin
                        spare_frames[free_top] = map_frame[slot + p];
                        free_top++;
                        returned++;
                    end
                    map_valid[slot + p] = 1'b0;
                end
            end
            held[req.process] = 0;
            res.freed_count = CNT_W'(returned);
        end else begin
            slot += req.page;
            if (map_valid[slot]) begin
                res.hit   = 1'b1;
                res.frame = map_frame[slot];
            end else begin
                fault_count++;
                res.fault = 1'b1;
                if (free_top == 0) begin
                    // nothing left to hand out, entry stays unmapped
                    res.out_of_frames = 1'b1;
                end else begin
                    free_top--;
                    map_frame[slot] = spare_frames[free_top];
                    map_valid[slot] = 1'b1;
                    held[req.process]++;
                    res.frame = map_frame[slot];
                end
            end
            res.process_frames = CNT_W'(held[req.process]);
        end
        res.free_left   = LEFT_W'(free_top);
        res.fault_total = fault_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_request(input page_action_t act, input int unsigned proc,
                               input int unsigned pg);
        page_request_t req;
        req.action  = act;
        req.process = PROC_W'(proc);
        req.page    = PAGE_W'(pg);
        request_queue.push_back(req);
    endtask

    // sender: bursts of transactions separated by random gaps, payload held until taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || fed) begin
                if (gap_left != 0 || request_queue.size() == 0) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end
                    s_valid <= 1'b0;
                end else begin
                    s_valid   <= 1'b1;
                    s_action  <= request_queue[0].action;
                    s_process <= request_queue[0].process;
                    s_page    <= request_queue[0].page;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // new burst; a third of them follow on with no gap at all
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            fed = 1'b0;
        end
    end

    // receiver: long hold-offs at two points in the run, otherwise a mode that changes now and then
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(32, 512);
        end else begin
            mode_left--;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (results_taken >= next_hold_at) begin
            // stall long enough for the block to back up into s_ready
            hold_left    = 400;
            next_hold_at = (next_hold_at == 30) ? 500 : 32'hFFFF_FFFF;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 9) < 3);
                end
            endcase
        end
    end

    // monitor: checks each result transaction, then records an accepted request
    always @(posedge aclk) begin : monitor
        page_result_t  want;
        page_request_t req;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_taken++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit",            want.hit,            m_hit);
                    check_field("fault",          want.fault,          m_fault);
                    check_field("out_of_frames",  want.out_of_frames,  m_out_of_frames);
                    check_field("frame",          want.frame,          m_frame);
                    check_field("freed_count",    want.freed_count,    m_freed_count);
                    check_field("process_frames", want.process_frames, m_process_frames);
                    check_field("free_left",      want.free_left,      m_free_left);
                    check_field("fault_total",    want.fault_total,    m_fault_total);
                end
            end
            if (s_valid && s_ready) begin
                req.action  = s_action;
                req.process = s_process;
                req.page    = s_page;
                expected_results.push_back(step_allocator(req));
                void'(request_queue.pop_front());
                fed = 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned pick;
        // tables empty, free stack slot i holds frame i
        for (int i = 0; i < NPROC * NPAGES; i++) begin
            map_frame[i] = '0;
            map_valid[i] = 1'b0;
        end
        for (int i = 0; i < NFRAMES; i++) begin
            spare_frames[i] = FRAME_W'(i);
        end
        for (int i = 0; i < NPROC; i++) begin
            held[i] = 0;
        end
        free_top    = NFRAMES;
        fault_count = '0;

        // directed: fault then hit at both page extremes, alternating bit patterns
        add_request(ACT_ACCESS, 0, 0);
        add_request(ACT_ACCESS, 0, 0);
        add_request(ACT_ACCESS, 7, NPAGES - 1);
        add_request(ACT_ACCESS, 7, NPAGES - 1);
        add_request(ACT_ACCESS, 5, 11'h555);
        add_request(ACT_ACCESS, 2, 11'h2AA);
        add_request(ACT_ACCESS, 0, 1);
        // release returns frames, the next fault must get the last one pushed
        add_request(ACT_RELEASE, 0, 0);
        add_request(ACT_ACCESS, 0, 0);
        add_request(ACT_ACCESS, 0, 1);
        // release of a process holding nothing, and a release repeated
        add_request(ACT_RELEASE, 3, NPAGES - 1);
        add_request(ACT_RELEASE, 7, 11'h555);
        add_request(ACT_RELEASE, 7, 0);
        add_request(ACT_ACCESS, 7, NPAGES - 1);
        add_request(ACT_ACCESS, 6, 1024);
        add_request(ACT_ACCESS, 6, 1024);
        add_request(ACT_ACCESS, 4, 11'h3FF);

        // release every process once, page field random
        for (int p = 0; p < NPROC; p++) begin
            add_request(ACT_RELEASE, p, $urandom_range(0, NPAGES - 1));
        end

        // random mix: mostly a small working set per process so hits and faults interleave
        for (int i = 0; i < 875; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                add_request(ACT_RELEASE, $urandom_range(0, NPROC - 1),
                            $urandom_range(0, NPAGES - 1));
            end else if (pick < 70) begin
                add_request(ACT_ACCESS, $urandom_range(0, NPROC - 1), $urandom_range(0, 15));
            end else begin
                add_request(ACT_ACCESS, $urandom_range(0, NPROC - 1),
                            $urandom_range(0, NPAGES - 1));
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (request_queue.size() != 0 || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        // room for a late release walk to show up if the block emits something extra
        repeat (NPAGES + 64) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("demand_page_frame_allocator verification clean");
        end else begin
            $display("demand_page_frame_allocator verification failed");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run including the clearing pass
    initial begin
        #40000000;
        $display("demand_page_frame_allocator verification failed");
        $finish;
    end

endmodule
